@@ sv/gh_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the gray histogram engine.
// No dependencies; imported by the top level.
package gh_pkg;

    localparam int OP_W      = 2;
    localparam int PIX_W     = 8;
    localparam int OUT_W     = 24;
    localparam int BAR_W     = 7;
    localparam int BAR_SCALE = 100;

    typedef logic [OP_W-1:0] t_op;

    localparam t_op OP_CLEAR = 2'd0;
    localparam t_op OP_COUNT = 2'd1;

endpackage

@@ sv/gh_ram.sv @@
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module gh_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ sv/gray_histogram_engine.sv @@
`timescale 1ns / 1ps
// Top level of the gray histogram engine: bin store, min/max tracking and bar divider.
// Depends on gh_pkg and gh_ram.
//
// The block handles one request at a time. A count or read request passes from acceptance
// to result through one memory read, one read-modify-write step, one scaling step, seven
// steps of the restoring divider that forms the bar length and one step to load the output
// register, which waits while an earlier result has not been taken. A count request that
// arrives after the last bin holding the smallest count has moved up first rescans the bin
// memory. A clear request sweeps zeros through every bin of the memory before its result,
// and the same sweep runs after reset, during which no request is accepted.
// A finished result waits in the output register while the next request is accepted.
module gray_histogram_engine
    import gh_pkg::*;
#(
    parameter int BIN_COUNT   = 256,
    parameter int COUNT_WIDTH = 24
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [OP_W-1:0]  i_operation,
    input  logic [PIX_W-1:0] i_pixel_value,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [OUT_W-1:0] o_bin_count,
    output logic [BAR_W-1:0] o_bar_length,
    output logic [OUT_W-1:0] o_low_count,
    output logic [OUT_W-1:0] o_high_count
);

    localparam int IDX_W  = $clog2(BIN_COUNT);
    localparam int PTR_W  = $clog2(BIN_COUNT + 1);
    localparam int NUM_W  = COUNT_WIDTH + BAR_W;
    localparam int MOD_W  = PIX_W + IDX_W + 1;
    localparam int STEP_W = $clog2(BAR_W);

    localparam logic [COUNT_WIDTH-1:0] LIMIT    = '1;
    localparam logic [PTR_W-1:0]       BIN_END  = PTR_W'(BIN_COUNT);
    localparam logic [PTR_W-1:0]       BIN_LAST = PTR_W'(BIN_COUNT - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_READ,
        S_MOD,
        S_MUL,
        S_DIV,
        S_DONE
    } t_state;

    t_state                  r_state;
    t_op                     r_op;
    logic [IDX_W-1:0]        r_idx;
    logic [IDX_W-1:0]        n_idx;
    logic [MOD_W-1:0]        mod_rem;
    logic [PTR_W-1:0]        r_ptr;
    logic                    r_clear_reply;
    logic                    r_scan_pend;
    logic                    r_scan_first;
    logic [COUNT_WIDTH-1:0]  r_min;
    logic [PTR_W-1:0]        r_min_num;
    logic                    r_min_stale;
    logic [COUNT_WIDTH-1:0]  r_max;
    logic [COUNT_WIDTH-1:0]  r_cnt;
    logic [NUM_W-1:0]        r_rem;
    logic [NUM_W-1:0]        r_den;
    logic [BAR_W-1:0]        r_quo;
    logic [STEP_W-1:0]       r_step;

    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    logic [COUNT_WIDTH-1:0]  ram_wdata;
    logic [IDX_W-1:0]        ram_raddr;
    logic [COUNT_WIDTH-1:0]  ram_rdata;
    logic [COUNT_WIDTH-1:0]  cnt_inc;

    // The pixel value is reduced modulo the bin count by shifted compare and subtract.
    always_comb begin
        mod_rem = MOD_W'(i_pixel_value);
        for (int k = PIX_W - 1; k >= 0; k--) begin
            if (mod_rem >= (MOD_W'(BIN_COUNT) << k)) begin
                mod_rem = mod_rem - (MOD_W'(BIN_COUNT) << k);
            end
        end
        n_idx = mod_rem[IDX_W-1:0];
    end

    assign cnt_inc   = (ram_rdata != LIMIT) ? ram_rdata + COUNT_WIDTH'(1) : ram_rdata;
    assign ram_we    = (r_state == S_CLEAR) || ((r_state == S_MOD) && (r_op == OP_COUNT));
    assign ram_waddr = (r_state == S_CLEAR) ? r_ptr[IDX_W-1:0] : r_idx;
    assign ram_wdata = (r_state == S_CLEAR) ? '0 : cnt_inc;
    assign ram_raddr = (r_state == S_SCAN) ? r_ptr[IDX_W-1:0] : r_idx;
    assign o_ready   = (r_state == S_IDLE);

    gh_ram #(
        .WIDTH(COUNT_WIDTH),
        .DEPTH(BIN_COUNT)
    ) u_bins (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_ptr         <= '0;
            r_clear_reply <= 1'b0;
            r_scan_pend   <= 1'b0;
            r_scan_first  <= 1'b0;
            r_min         <= '0;
            r_min_num     <= BIN_END;
            r_min_stale   <= 1'b0;
            r_max         <= '0;
            o_valid       <= 1'b0;
        end else begin
            if (o_valid && i_ready && (r_state != S_DONE)) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    if (r_ptr == BIN_LAST) begin
                        r_min       <= '0;
                        r_min_num   <= BIN_END;
                        r_min_stale <= 1'b0;
                        r_max       <= '0;
                        r_cnt       <= '0;
                        r_quo       <= '0;
                        r_state     <= r_clear_reply ? S_DONE : S_IDLE;
                    end else begin
                        r_ptr <= r_ptr + PTR_W'(1);
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_op  <= i_operation;
                        r_idx <= n_idx;
                        r_ptr <= '0;
                        if (i_operation == OP_CLEAR) begin
                            r_clear_reply <= 1'b1;
                            r_state       <= S_CLEAR;
                        end else if ((i_operation == OP_COUNT) && r_min_stale) begin
                            r_scan_pend  <= 1'b0;
                            r_scan_first <= 1'b1;
                            r_state      <= S_SCAN;
                        end else begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_scan_pend) begin
                        if (r_scan_first || (ram_rdata < r_min)) begin
                            r_min     <= ram_rdata;
                            r_min_num <= PTR_W'(1);
                        end else if (ram_rdata == r_min) begin
                            r_min_num <= r_min_num + PTR_W'(1);
                        end
                        r_scan_first <= 1'b0;
                    end
                    if (r_ptr != BIN_END) begin
                        r_ptr       <= r_ptr + PTR_W'(1);
                        r_scan_pend <= 1'b1;
                    end else begin
                        r_scan_pend <= 1'b0;
                        if (r_scan_pend) begin
                            r_min_stale <= 1'b0;
                            r_state     <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_MOD;
                end
                S_MOD: begin
                    if (r_op == OP_COUNT) begin
                        r_cnt <= cnt_inc;
                        if ((ram_rdata == r_min) && (ram_rdata != LIMIT)) begin
                            if (r_min_num == PTR_W'(1)) begin
                                r_min       <= r_min + COUNT_WIDTH'(1);
                                r_min_stale <= 1'b1;
                            end else begin
                                r_min_num <= r_min_num - PTR_W'(1);
                            end
                        end
                        if (cnt_inc > r_max) begin
                            r_max <= cnt_inc;
                        end
                    end else begin
                        r_cnt <= ram_rdata;
                    end
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_rem   <= NUM_W'(r_cnt) * NUM_W'(BAR_SCALE);
                    r_den   <= NUM_W'(r_max) << (BAR_W - 1);
                    r_quo   <= '0;
                    r_step  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_rem >= r_den) begin
                        r_rem <= r_rem - r_den;
                        r_quo <= {r_quo[BAR_W-2:0], 1'b1};
                    end else begin
                        r_quo <= {r_quo[BAR_W-2:0], 1'b0};
                    end
                    r_den  <= r_den >> 1;
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == STEP_W'(BAR_W - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!o_valid || i_ready) begin
                        o_valid      <= 1'b1;
                        o_bin_count  <= OUT_W'(r_cnt);
                        o_bar_length <= (r_max == '0) ? '0 : r_quo;
                        o_low_count  <= OUT_W'(r_min);
                        o_high_count <= OUT_W'(r_max);
                        r_state      <= S_IDLE;
                    end
                end
            endcase
        end
    end

    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_min <= r_max)
        else $error("Smallest bin count exceeds largest bin count.");

    a_min_num_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_min_stale |-> (r_min_num != '0))
        else $error("No bin is recorded at the smallest count.");

    a_bar_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_bar_length <= BAR_W'(BAR_SCALE)))
        else $error("Bar length is out of range.");

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !ram_we)
        else $error("Bin memory written while idle.");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state != S_IDLE))
        else $error("Accepted request did not start.");

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for gray_histogram_engine: directed and random clear, count and
// read requests, with a scoreboard of predicted readings. Depends on gh_pkg and the engine.
module tb_top;
    import gh_pkg::*;

    localparam int  NUM_BINS     = 256;
    localparam int  CNT_W        = 24;
    localparam int  RAND_ITEMS   = 1450;
    localparam int  TAIL_ITEMS   = 150;
    localparam int  HOLD_AFTER   = 400;
    localparam int  HOLD_CYCLES  = 300;
    localparam int  DRAIN_CYCLES = 40;
    localparam int  STALL_LIMIT  = 5000;
    localparam t_op OP_READ      = 2'd2;
    localparam t_op OP_SPARE     = 2'd3;

    typedef struct {
        t_op              op;
        logic [PIX_W-1:0] pix;
    } t_pix_req;

    typedef struct {
        logic [OUT_W-1:0] bin_count;
        logic [BAR_W-1:0] bar_length;
        logic [OUT_W-1:0] low_count;
        logic [OUT_W-1:0] high_count;
    } t_hist_reading;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic             o_ready;
    logic [OP_W-1:0]  i_operation = '0;
    logic [PIX_W-1:0] i_pixel_value = '0;
    logic             o_valid;
    logic             i_ready = 1'b0;
    logic [OUT_W-1:0] o_bin_count;
    logic [BAR_W-1:0] o_bar_length;
    logic [OUT_W-1:0] o_low_count;
    logic [OUT_W-1:0] o_high_count;

    t_pix_req      pending_reqs[$];
    t_hist_reading expected_readings[$];
    logic [CNT_W-1:0] hist_bins[NUM_BINS];
    logic [CNT_W-1:0] hist_peak;

    int   err_count     = 0;
    int   reqs_accepted = 0;
    int   results_seen  = 0;
    int   total_reqs    = 0;
    int   stall_cycles  = 0;
    logic req_taken     = 1'b0;
    logic tail_mode     = 1'b0;

    int   src_gap       = 0;
    int   src_mode_left = 0;
    logic src_idle_on   = 1'b1;
    int   sink_gap       = 0;
    int   sink_mode_left = 0;
    logic sink_idle_on   = 1'b1;
    int   hold_left      = 0;
    logic hold_done      = 1'b0;

    gray_histogram_engine #(
        .BIN_COUNT   (NUM_BINS),
        .COUNT_WIDTH (CNT_W)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_operation   (i_operation),
        .i_pixel_value (i_pixel_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_bin_count   (o_bin_count),
        .o_bar_length  (o_bar_length),
        .o_low_count   (o_low_count),
        .o_high_count  (o_high_count)
    );

    always #5 i_clk = ~i_clk;

    task automatic add_req(t_op op, logic [PIX_W-1:0] pix);
        t_pix_req req;
        req.op  = op;
        req.pix = pix;
        pending_reqs.push_back(req);
    endtask

    function automatic t_hist_reading hist_apply(t_pix_req req);
        t_hist_reading    r;
        logic [CNT_W-1:0] cnt;
        logic [CNT_W-1:0] low;
        longint           quot;
        int               idx;
        idx = int'(req.pix) % NUM_BINS;
        if (req.op == OP_CLEAR) begin
            foreach (hist_bins[b]) hist_bins[b] = '0;
            hist_peak = '0;
        end else if (req.op == OP_COUNT) begin
            if (hist_bins[idx] != {CNT_W{1'b1}}) begin
                hist_bins[idx] = hist_bins[idx] + 1'b1;
            end
            if (hist_bins[idx] > hist_peak) begin
                hist_peak = hist_bins[idx];
            end
        end
        cnt = hist_bins[idx];
        low = hist_bins[0];
        foreach (hist_bins[b]) begin
            if (hist_bins[b] < low) begin
                low = hist_bins[b];
            end
        end
        quot = 0;
        if (hist_peak != '0) begin
            quot = (longint'(cnt) * BAR_SCALE) / longint'(hist_peak);
        end
        r.bin_count  = cnt[OUT_W-1:0];
        r.bar_length = BAR_W'(quot);
        r.low_count  = low[OUT_W-1:0];
        r.high_count = hist_peak[OUT_W-1:0];
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            err_count++;
        end
    endtask

    // Request driver: inputs change on the falling edge only.
    always @(negedge i_clk) begin
        t_pix_req next_req;
        if (src_mode_left == 0) begin
            src_mode_left <= $urandom_range(20, 80);
            src_idle_on   <= ($urandom_range(0, 2) != 0);
        end else begin
            src_mode_left <= src_mode_left - 1;
        end
        if (i_rst_n && (!i_valid || req_taken)) begin
            if (src_gap > 0) begin
                i_valid <= 1'b0;
                src_gap <= src_gap - 1;
            end else if (pending_reqs.size() > 0) begin
                next_req = pending_reqs.pop_front();
                i_valid       <= 1'b1;
                i_operation   <= next_req.op;
                i_pixel_value <= next_req.pix;
                if (!tail_mode && src_idle_on && $urandom_range(0, 3) == 0) begin
                    src_gap <= $urandom_range(1, 9);
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
        tail_mode <= (pending_reqs.size() < TAIL_ITEMS);
    end

    // Result sink: random back-pressure and one long hold-off.
    always @(negedge i_clk) begin
        if (sink_mode_left == 0) begin
            sink_mode_left <= $urandom_range(20, 80);
            sink_idle_on   <= ($urandom_range(0, 2) != 0);
        end else begin
            sink_mode_left <= sink_mode_left - 1;
        end
        if (hold_left > 0) begin
            i_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            i_ready   <= 1'b0;
            hold_left <= HOLD_CYCLES - 1;
            hold_done <= 1'b1;
        end else if (sink_gap > 0) begin
            i_ready  <= 1'b0;
            sink_gap <= sink_gap - 1;
        end else if (!tail_mode && sink_idle_on && $urandom_range(0, 4) == 0) begin
            i_ready  <= 1'b0;
            sink_gap <= $urandom_range(0, 8);
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_hist_reading want;
        t_pix_req      req;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                results_seen++;
                if (expected_readings.size() == 0) begin
                    $display("%0t: result with no request pending, expected none, actual %0d",
                             $time, o_bin_count);
                    err_count++;
                end else begin
                    want = expected_readings.pop_front();
                    check_field("bin_count", want.bin_count, o_bin_count);
                    check_field("bar_length", want.bar_length, o_bar_length);
                    check_field("low_count", want.low_count, o_low_count);
                    check_field("high_count", want.high_count, o_high_count);
                end
            end
            if (i_valid && o_ready) begin
                req.op  = i_operation;
                req.pix = i_pixel_value;
                expected_readings.push_back(hist_apply(req));
                reqs_accepted++;
            end
        end
        req_taken <= i_rst_n && i_valid && o_ready;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && !((i_valid && o_ready) || (o_valid && i_ready))) begin
            stall_cycles++;
        end else begin
            stall_cycles = 0;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, stall_cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int               kind;
        int               sweeps_done;
        int               span;
        int               roll;
        int               pick;
        logic [PIX_W-1:0] base;
        logic [PIX_W-1:0] swap;
        logic [PIX_W-1:0] order[NUM_BINS];
        t_op              op;

        foreach (hist_bins[b]) hist_bins[b] = '0;
        hist_peak   = '0;
        sweeps_done = 0;

        add_req(OP_READ, 8'd0);
        add_req(OP_READ, 8'd255);
        add_req(OP_SPARE, 8'd7);
        add_req(OP_COUNT, 8'd0);
        add_req(OP_COUNT, 8'd255);
        add_req(OP_COUNT, 8'd255);
        add_req(OP_READ, 8'd255);
        add_req(OP_READ, 8'd0);
        add_req(OP_READ, 8'd128);
        add_req(OP_SPARE, 8'd255);
        add_req(OP_COUNT, 8'h55);
        add_req(OP_COUNT, 8'hAA);
        add_req(OP_COUNT, 8'h80);
        add_req(OP_COUNT, 8'h7F);
        add_req(OP_CLEAR, 8'h3C);
        add_req(OP_READ, 8'd255);
        add_req(OP_COUNT, 8'd200);
        add_req(OP_COUNT, 8'd200);
        add_req(OP_COUNT, 8'd200);
        add_req(OP_COUNT, 8'd17);
        add_req(OP_READ, 8'd17);
        add_req(OP_SPARE, 8'd200);
        add_req(OP_CLEAR, 8'd255);
        add_req(OP_READ, 8'd0);

        // Full sweeps over every bin are what lift the smallest count above zero.
        while (pending_reqs.size() < RAND_ITEMS) begin
            kind = $urandom_range(0, 9);
            if (kind == 0 && sweeps_done < 3) begin
                sweeps_done++;
                if ($urandom_range(0, 1) == 0) add_req(OP_CLEAR, 8'($urandom));
                foreach (order[p]) order[p] = PIX_W'(p);
                for (int p = NUM_BINS - 1; p > 0; p--) begin
                    pick        = $urandom_range(0, p);
                    swap        = order[p];
                    order[p]    = order[pick];
                    order[pick] = swap;
                end
                foreach (order[p]) begin
                    add_req(OP_COUNT, order[p]);
                    if ($urandom_range(0, 15) == 0) add_req(OP_READ, 8'($urandom));
                end
            end else if (kind <= 2) begin
                base = 8'($urandom);
                span = $urandom_range(0, 7);
                repeat ($urandom_range(20, 50)) begin
                    op = ($urandom_range(0, 3) == 0) ? OP_READ : OP_COUNT;
                    add_req(op, base + 8'($urandom_range(0, span)));
                end
            end else if (kind == 9) begin
                repeat ($urandom_range(5, 15)) begin
                    op = ($urandom_range(0, 4) == 0) ? OP_SPARE : OP_READ;
                    add_req(op, 8'($urandom));
                end
            end else begin
                repeat ($urandom_range(10, 40)) begin
                    roll = $urandom_range(0, 99);
                    op = (roll < 2) ? OP_CLEAR : (roll < 8) ? OP_SPARE :
                         (roll < 38) ? OP_READ : OP_COUNT;
                    add_req(op, 8'($urandom));
                end
            end
        end
        total_reqs = pending_reqs.size();

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (reqs_accepted < total_reqs) @(posedge i_clk);
        while (expected_readings.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (expected_readings.size() != 0) begin
            $display("%0t: results outstanding, expected 0, actual %0d",
                     $time, expected_readings.size());
            err_count++;
        end
        if (err_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
